### src/dark_pixel_centroid_bbox_macros.svh
// Assertion macros shared by the checking code of the dark-pixel centroid block.
`ifndef DARK_PIXEL_CENTROID_BBOX_MACROS_SVH
`define DARK_PIXEL_CENTROID_BBOX_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define DPCB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define DPCB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/dpcb_pkg.sv
// ----------------------------------------------------------------------------
// dpcb_pkg
// Types and constants of the dark-pixel centroid and bounding box block.
// ----------------------------------------------------------------------------
package dpcb_pkg;

   localparam int PixelBits  = 8;
   localparam int CoordBits  = 12;
   localparam int LimitBits  = 24;
   localparam int CountBits  = LimitBits + 1;
   localparam int SumBits    = LimitBits + CoordBits;
   localparam int DivSteps   = CoordBits;
   localparam int StepBits   = $clog2(DivSteps);

   localparam logic [PixelBits-1:0] ThreshReset = PixelBits'(200);
   localparam logic [PixelBits-1:0] WhiteLevel  = PixelBits'(255);
   localparam logic [PixelBits-1:0] BlackLevel  = PixelBits'(0);
   localparam logic [CountBits-1:0] DarkLimit   = CountBits'(1) << LimitBits;

   typedef struct packed {
      logic [PixelBits-1:0] pixel_value;
      logic [CoordBits-1:0] pixel_x;
      logic [CoordBits-1:0] pixel_y;
      logic                 frame_end;
   } req_type;

   typedef struct packed {
      logic [PixelBits-1:0] binary_pixel;
      logic                 stats_valid;
      logic                 empty_frame;
      logic [CountBits-1:0] dark_total;
      logic [CoordBits-1:0] mean_x;
      logic [CoordBits-1:0] mean_y;
      logic [CoordBits-1:0] box_left;
      logic [CoordBits-1:0] box_right;
      logic [CoordBits-1:0] box_top;
      logic [CoordBits-1:0] box_bottom;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_LOAD,
      ST_DIVIDE,
      ST_REPORT
   } state_type;

   typedef struct packed {
      logic take_pixel;
      logic load_div;
      logic div_step;
      logic load_stats;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

### src/dpcb_ctrl.sv
// ----------------------------------------------------------------------------
// dpcb_ctrl
// Sequencer: pixel acceptance, the frame-end divide sequence and the
// result beat's valid flag.
// ----------------------------------------------------------------------------
module dpcb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_frame_end,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dpcb_pkg::cmd_type    cmd,
   input  dpcb_pkg::status_type status
);
   import dpcb_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;

   assign req_ready = !reset && (state_ff == ST_RUN) && (!rsp_valid_ff || rsp_ready);
   assign take      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN: begin
            if (take && req_frame_end) state_in = ST_LOAD;
         end
         ST_LOAD:   state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_REPORT;
         end
         ST_REPORT: state_in = ST_RUN;
         default:   state_in = ST_RUN;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.take_pixel = take;
      cmd.load_div   = (state_ff == ST_LOAD);
      cmd.div_step   = (state_ff == ST_DIVIDE);
      cmd.load_stats = (state_ff == ST_REPORT);
   end

   // The frame-end beat is held back until the statistics are ready.
   always_comb begin
      priority if (take) begin
         rsp_valid_in = !req_frame_end;
      end else if (state_ff == ST_REPORT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### src/dpcb_datapath.sv
// ----------------------------------------------------------------------------
// dpcb_datapath
// Threshold register, frame accumulators, two-lane restoring divider and
// the result register.
// ----------------------------------------------------------------------------
module dpcb_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [dpcb_pkg::PixelBits-1:0] csr_data,
   input  dpcb_pkg::req_type              req_data,
   output dpcb_pkg::rsp_type              rsp_data,
   input  dpcb_pkg::cmd_type              cmd,
   output dpcb_pkg::status_type           status
);
   import dpcb_pkg::*;

   logic [PixelBits-1:0] thresh_ff, thresh_in;
   logic [SumBits-1:0]   sum_cols_ff, sum_cols_in;
   logic [SumBits-1:0]   sum_rows_ff, sum_rows_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic [CoordBits-1:0] least_col_ff, least_col_in;
   logic [CoordBits-1:0] greatest_col_ff, greatest_col_in;
   logic [CoordBits-1:0] least_row_ff, least_row_in;
   logic [CoordBits-1:0] greatest_row_ff, greatest_row_in;

   logic [CountBits-1:0] rem_x_ff, rem_x_in;
   logic [CountBits-1:0] rem_y_ff, rem_y_in;
   logic [CoordBits-1:0] quo_x_ff, quo_x_in;
   logic [CoordBits-1:0] quo_y_ff, quo_y_in;
   logic [StepBits-1:0]  step_ff, step_in;

   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 dark;
   logic [CountBits:0]   trial_x, trial_y;
   logic                 fit_x, fit_y;

   assign dark      = !(req_data.pixel_value > thresh_ff);
   assign thresh_in = csr_write ? csr_data : thresh_ff;

   always_comb begin
      sum_cols_in     = sum_cols_ff;
      sum_rows_in     = sum_rows_ff;
      count_in        = count_ff;
      least_col_in    = least_col_ff;
      greatest_col_in = greatest_col_ff;
      least_row_in    = least_row_ff;
      greatest_row_in = greatest_row_ff;
      if (cmd.load_stats) begin
         sum_cols_in     = '0;
         sum_rows_in     = '0;
         count_in        = '0;
         least_col_in    = '1;
         greatest_col_in = '0;
         least_row_in    = '1;
         greatest_row_in = '0;
      end else if (cmd.take_pixel && dark) begin
         // Past the count limit the sums freeze but the box keeps growing.
         if (count_ff < DarkLimit) begin
            count_in    = count_ff + CountBits'(1);
            sum_cols_in = sum_cols_ff + SumBits'(req_data.pixel_x);
            sum_rows_in = sum_rows_ff + SumBits'(req_data.pixel_y);
         end
         if (req_data.pixel_x < least_col_ff)    least_col_in    = req_data.pixel_x;
         if (req_data.pixel_x > greatest_col_ff) greatest_col_in = req_data.pixel_x;
         if (req_data.pixel_y < least_row_ff)    least_row_in    = req_data.pixel_y;
         if (req_data.pixel_y > greatest_row_ff) greatest_row_in = req_data.pixel_y;
      end
   end

   // The mean always fits in CoordBits, so the upper sum bits start out as
   // a partial remainder below the count and only CoordBits steps remain.
   assign trial_x = {rem_x_ff, quo_x_ff[CoordBits-1]};
   assign trial_y = {rem_y_ff, quo_y_ff[CoordBits-1]};
   assign fit_x   = trial_x >= {1'b0, count_ff};
   assign fit_y   = trial_y >= {1'b0, count_ff};

   always_comb begin
      rem_x_in = rem_x_ff;
      rem_y_in = rem_y_ff;
      quo_x_in = quo_x_ff;
      quo_y_in = quo_y_ff;
      step_in  = step_ff;
      if (cmd.load_div) begin
         rem_x_in = CountBits'(sum_cols_ff[SumBits-1:CoordBits]);
         rem_y_in = CountBits'(sum_rows_ff[SumBits-1:CoordBits]);
         quo_x_in = sum_cols_ff[CoordBits-1:0];
         quo_y_in = sum_rows_ff[CoordBits-1:0];
         step_in  = '0;
      end else if (cmd.div_step) begin
         rem_x_in = fit_x ? CountBits'(trial_x - {1'b0, count_ff}) : trial_x[CountBits-1:0];
         rem_y_in = fit_y ? CountBits'(trial_y - {1'b0, count_ff}) : trial_y[CountBits-1:0];
         quo_x_in = {quo_x_ff[CoordBits-2:0], fit_x};
         quo_y_in = {quo_y_ff[CoordBits-2:0], fit_y};
         step_in  = step_ff + StepBits'(1);
      end
   end

   assign status.div_last = (step_ff == StepBits'(DivSteps - 1));

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.take_pixel) begin
         rsp_data_in              = '0;
         rsp_data_in.binary_pixel = dark ? BlackLevel : WhiteLevel;
      end else if (cmd.load_stats) begin
         rsp_data_in.stats_valid = 1'b1;
         if (count_ff == '0) begin
            rsp_data_in.empty_frame = 1'b1;
         end else begin
            rsp_data_in.dark_total = count_ff;
            rsp_data_in.mean_x     = quo_x_ff;
            rsp_data_in.mean_y     = quo_y_ff;
            rsp_data_in.box_left   = least_col_ff;
            rsp_data_in.box_right  = greatest_col_ff;
            rsp_data_in.box_top    = least_row_ff;
            rsp_data_in.box_bottom = greatest_row_ff;
         end
      end
   end

   assign rsp_data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff       <= ThreshReset;
         sum_cols_ff     <= '0;
         sum_rows_ff     <= '0;
         count_ff        <= '0;
         least_col_ff    <= '1;
         greatest_col_ff <= '0;
         least_row_ff    <= '1;
         greatest_row_ff <= '0;
         step_ff         <= '0;
      end else begin
         thresh_ff       <= thresh_in;
         sum_cols_ff     <= sum_cols_in;
         sum_rows_ff     <= sum_rows_in;
         count_ff        <= count_in;
         least_col_ff    <= least_col_in;
         greatest_col_ff <= greatest_col_in;
         least_row_ff    <= least_row_in;
         greatest_row_ff <= greatest_row_in;
         step_ff         <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_x_ff    <= rem_x_in;
      rem_y_ff    <= rem_y_in;
      quo_x_ff    <= quo_x_in;
      quo_y_ff    <= quo_y_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### src/dark_pixel_centroid_bbox.sv
// Dark-pixel centroid and bounding box. Takes one pixel beat per cycle with
// its column, row and end-of-frame mark, and returns one beat per pixel:
// the thresholded pixel, plus frame statistics (dark count, truncated mean
// column and row, bounding box) on the frame's last pixel. Ordinary pixels
// go through at one per cycle as long as the result side keeps up. Once the
// frame-end pixel is taken, input is held off while the block loads the
// divider from the accumulators, runs the 12 steps of the two-lane restoring
// divider that forms both means in parallel, and loads the result. The
// threshold register may be written at any cycle outside reset.
// ----------------------------------------------------------------------------
// dark_pixel_centroid_bbox
// Top level: joins the sequencer and the datapath.
// ----------------------------------------------------------------------------
module dark_pixel_centroid_bbox (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [dpcb_pkg::PixelBits-1:0] csr_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  dpcb_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output dpcb_pkg::rsp_type              rsp_data
);
   import dpcb_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = !reset;

   dpcb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_frame_end (req_data.frame_end),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd),
      .status        (status)
   );

   dpcb_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

### src/dpcb_checker.sv
// ----------------------------------------------------------------------------
// dpcb_checker
// Port-level checks of the dark-pixel centroid block, bound to its top level.
// ----------------------------------------------------------------------------
`include "dark_pixel_centroid_bbox_macros.svh"

module dpcb_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input dpcb_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dpcb_pkg::rsp_type rsp_data
);
   import dpcb_pkg::*;

   // A stalled result beat keeps its payload.
   `DPCB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result beat changed")

   // The frame-end pixel blocks input while the means are computed.
   `DPCB_ASSERT_NXT(a_end_stalls, clock, reset, req_valid && req_ready && req_data.frame_end, !req_ready, "input taken during frame-end divide")

   // Ordinary pixel beats carry no statistics.
   `DPCB_ASSERT_IMP(a_plain_zero, clock, reset, rsp_valid && !rsp_data.stats_valid, !rsp_data.empty_frame && rsp_data.dark_total == '0 && rsp_data.mean_x == '0 && rsp_data.mean_y == '0 && rsp_data.box_right == '0 && rsp_data.box_bottom == '0, "statistics on an ordinary pixel beat")

   // An empty frame reports zeros; a non-empty one has its means inside the box.
   `DPCB_ASSERT_IMP(a_empty_zero, clock, reset, rsp_valid && rsp_data.empty_frame, rsp_data.stats_valid && rsp_data.dark_total == '0 && rsp_data.mean_x == '0 && rsp_data.box_right == '0, "empty frame with nonzero results")
   `DPCB_ASSERT_IMP(a_mean_in_box, clock, reset, rsp_valid && rsp_data.stats_valid && !rsp_data.empty_frame, rsp_data.dark_total != '0 && rsp_data.mean_x >= rsp_data.box_left && rsp_data.mean_x <= rsp_data.box_right && rsp_data.mean_y >= rsp_data.box_top && rsp_data.mean_y <= rsp_data.box_bottom, "mean outside bounding box")

endmodule

bind dark_pixel_centroid_bbox dpcb_checker u_dpcb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
